// File: rtl/core/vfm_pkg.sv
// Shared types, constants and lookup functions for the voxel face mesher.
package vfm_pkg;

  localparam int unsigned NumFaces     = 6;
  localparam int unsigned VertsPerFace = 6;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned ChunkW       = 16;
  localparam int unsigned ChunkH       = 16;
  localparam int unsigned ChunkD       = 16;

  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned MaskW     = 27;

  // Face codes
  localparam logic [2:0] FaceTop  = 3'd0;
  localparam logic [2:0] FaceBot  = 3'd1;
  localparam logic [2:0] FacePosX = 3'd2;
  localparam logic [2:0] FaceNegX = 3'd3;
  localparam logic [2:0] FacePosZ = 3'd4;
  localparam logic [2:0] FaceNegZ = 3'd5;

  localparam logic [2:0] VertFirst = 3'd0;
  localparam logic [2:0] VertLast  = 3'(VertsPerFace - 1);

  // AO letter groups: a=bit0 .. h=bit7
  localparam logic [7:0] LetCde = 8'h1C;
  localparam logic [7:0] LetBcf = 8'h26;
  localparam logic [7:0] LetAbg = 8'h43;
  localparam logic [7:0] LetAdh = 8'h89;

  // Mask bit of each face's direct neighbor, face 5 first
  localparam logic [NumFaces-1:0][4:0] OpenBit = {
    5'd10, 5'd16, 5'd12, 5'd14, 5'd4, 5'd22
  };

  // Mask bits of AO letters h..a per face, face 5 first
  localparam logic [NumFaces-1:0][7:0][4:0] AoBit = {
    {5'd18, 5'd20, 5'd2,  5'd0, 5'd9,  5'd1, 5'd11, 5'd19},
    {5'd24, 5'd26, 5'd8,  5'd6, 5'd15, 5'd7, 5'd17, 5'd25},
    {5'd18, 5'd24, 5'd6,  5'd0, 5'd9,  5'd3, 5'd15, 5'd21},
    {5'd20, 5'd26, 5'd8,  5'd2, 5'd11, 5'd5, 5'd17, 5'd23},
    {5'd2,  5'd8,  5'd6,  5'd0, 5'd1,  5'd3, 5'd7,  5'd5},
    {5'd20, 5'd26, 5'd24, 5'd18, 5'd19, 5'd21, 5'd25, 5'd23}
  };

  typedef struct packed {
    logic [3:0]                x;
    logic [3:0]                y;
    logic [3:0]                z;
    logic [3:0]                u1;
    logic [3:0]                v1;
    logic [NumFaces-1:0]       open;
    logic [NumFaces-1:0][7:0]  letters;
  } vfm_item_t;

  typedef struct packed {
    logic       ox;
    logic       oy;
    logic       oz;
    logic       us;
    logic       vs;
    logic [7:0] aomask;
  } vfm_vert_t;

  function automatic logic [3:0] sat_coord(logic [3:0] c, int unsigned size);
    logic [3:0] r;
    r = c;
    if (32'(c) >= size) r = 4'(size - 1);
    return r;
  endfunction

  function automatic vfm_vert_t mk_vert(logic ox, logic oy, logic oz, logic us,
                                        logic vs, logic [7:0] m);
    vfm_vert_t v;
    v.ox = ox; v.oy = oy; v.oz = oz; v.us = us; v.vs = vs; v.aomask = m;
    return v;
  endfunction

  // Corner offsets, UV offsets and AO letter group of each face vertex
  function automatic vfm_vert_t vert_lut(logic [2:0] face, logic [2:0] k);
    vfm_vert_t v;
    v = mk_vert(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LetCde);
    unique case (face)
      FaceTop: begin
        unique case (k)
          3'd1:    v = mk_vert(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, LetBcf);
          3'd2:    v = mk_vert(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, LetAbg);
          3'd4:    v = mk_vert(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, LetAbg);
          3'd5:    v = mk_vert(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, LetAdh);
          default: v = mk_vert(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, LetCde);
        endcase
      end
      FaceBot: begin
        unique case (k)
          3'd1:    v = mk_vert(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, LetAbg);
          3'd2:    v = mk_vert(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, LetAbg);
          3'd4:    v = mk_vert(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, LetAdh);
          3'd5:    v = mk_vert(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, LetAbg);
          default: v = mk_vert(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LetCde);
        endcase
      end
      FacePosX: begin
        unique case (k)
          3'd1:    v = mk_vert(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, LetAdh);
          3'd2:    v = mk_vert(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, LetAbg);
          3'd4:    v = mk_vert(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, LetAbg);
          3'd5:    v = mk_vert(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, LetBcf);
          default: v = mk_vert(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, LetCde);
        endcase
      end
      FaceNegX: begin
        unique case (k)
          3'd1:    v = mk_vert(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, LetAbg);
          3'd2:    v = mk_vert(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, LetAdh);
          3'd4:    v = mk_vert(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, LetBcf);
          3'd5:    v = mk_vert(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, LetAbg);
          default: v = mk_vert(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LetCde);
        endcase
      end
      FacePosZ: begin
        unique case (k)
          3'd1:    v = mk_vert(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, LetAbg);
          3'd2:    v = mk_vert(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, LetAdh);
          3'd4:    v = mk_vert(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, LetBcf);
          3'd5:    v = mk_vert(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, LetAbg);
          default: v = mk_vert(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, LetCde);
        endcase
      end
      FaceNegZ: begin
        unique case (k)
          3'd1:    v = mk_vert(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, LetAdh);
          3'd2:    v = mk_vert(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, LetAbg);
          3'd4:    v = mk_vert(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, LetAbg);
          3'd5:    v = mk_vert(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, LetBcf);
          default: v = mk_vert(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, LetCde);
        endcase
      end
      default: v = mk_vert(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LetCde);
    endcase
    return v;
  endfunction

  // Q12 brightness by face and blocked count
  function automatic logic [12:0] light_lut(logic [2:0] face, logic [1:0] n);
    logic [3:0][12:0] row;
    unique case (face)
      FaceTop:  row = {13'd2253, 13'd2867, 13'd3482, 13'd4096};
      FaceBot:  row = {13'd1690, 13'd2150, 13'd2611, 13'd3072};
      FacePosX: row = {13'd2140, 13'd2724, 13'd3308, 13'd3891};
      FaceNegX: row = {13'd1915, 13'd2437, 13'd2959, 13'd3482};
      FacePosZ: row = {13'd2028, 13'd2580, 13'd3133, 13'd3686};
      FaceNegZ: row = {13'd1802, 13'd2294, 13'd2785, 13'd3277};
      default:  row = '0;
    endcase
    return row[n];
  endfunction

endpackage

// File: rtl/core/voxel_face_mesher_ao.sv
// Voxel face mesher with AO: top level joining front, queue and back.
// A voxel's first vertex passes the descriptor queue, the back-end voxel
// register and the output register. The vertex walker emits one vertex per
// cycle unless the output stalls; empty or enclosed voxels emit nothing.
// The input side keeps accepting while the 2-entry descriptor queue has room.
// Reset (rst_ni low, asynchronous) empties queue and output, sets use_ao to 1.
module voxel_face_mesher_ao (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // use_ao
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // vox_x[3:0], vox_y[7:4], vox_z[11:8], block_id[19:12], neighbor_mask[46:20]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // corner_x[4:0], corner_y[9:5], corner_z[14:10], tex_u[19:15], tex_v[24:20],
  // light[37:25]
  output logic [39:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,  // face[2:0]
  output logic        m_axis_tlast_o   // last
);
  import vfm_pkg::*;

  logic      q_full, q_push, q_pop, q_valid;
  vfm_item_t q_in, q_out;

  vfm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  vfm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  vfm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_out),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_user_o  (m_axis_tuser_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

// File: rtl/core/vfm_front.sv
// Front end: takes voxel words, culls faces and gathers AO letters per face.
module vfm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [vfm_pkg::InDataW-1:0]  s_data_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output vfm_pkg::vfm_item_t           q_item_o
);
  import vfm_pkg::*;

  logic             use_ao_q, use_ao_d;
  logic [3:0]       vx, vy, vz;
  logic [7:0]       id;
  logic [MaskW-1:0] nb;
  vfm_item_t        item;

  assign use_ao_d = cfg_we_i ? cfg_wdata_i : use_ao_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_ao_q <= 1'b1;
    end else begin
      use_ao_q <= use_ao_d;
    end
  end

  assign vx = s_data_i[3:0];
  assign vy = s_data_i[7:4];
  assign vz = s_data_i[11:8];
  assign id = s_data_i[19:12];
  assign nb = s_data_i[46:20];

  always_comb begin
    item.x  = sat_coord(vx, ChunkW);
    item.y  = sat_coord(vy, ChunkH);
    item.z  = sat_coord(vz, ChunkD);
    item.u1 = id[3:0];
    item.v1 = 4'd15 - id[7:4];
    for (int f = 0; f < NumFaces; f++) begin
      item.open[f] = ~nb[OpenBit[f]];
      for (int l = 0; l < 8; l++) begin
        item.letters[f][l] = use_ao_q & nb[AoBit[f][l]];
      end
    end
  end

  assign s_ready_o = ~q_full_i;
  // drop empty and fully enclosed voxels here
  assign q_push_o  = s_valid_i & ~q_full_i & (id != 8'd0) & (item.open != '0);
  assign q_item_o  = item;

endmodule

// File: rtl/core/vfm_queue.sv
// Short queue of culled voxel descriptors between front and back.
module vfm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vfm_pkg::vfm_item_t  item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output vfm_pkg::vfm_item_t  item_o
);
  import vfm_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  vfm_item_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

// File: rtl/core/vfm_back.sv
// Back end: walks the open faces of one voxel and emits one vertex per cycle while the output is not stalled.
module vfm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  vfm_pkg::vfm_item_t            q_item_i,
  output logic                          q_pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [vfm_pkg::OutDataW-1:0]  m_data_o,
  output logic [2:0]                    m_user_o,
  output logic                          m_last_o
);
  import vfm_pkg::*;

  vfm_item_t           cur_q;
  logic                busy_q, busy_d;
  logic [NumFaces-1:0] rem_q, rem_d, rem_after;
  logic [2:0]          k_q, k_d;
  logic [2:0]          face;
  logic                out_ready, emit, finish, load;
  vfm_vert_t           vd;
  logic [7:0]          sel;
  logic [3:0]          cnt;
  logic [1:0]          n;

  logic                ov_q, ov_d;
  logic [4:0]          cx_q, cy_q, cz_q, tu_q, tv_q;
  logic [12:0]         light_q;
  logic [2:0]          face_q;
  logic                last_q;

  // lowest pending face goes first
  always_comb begin
    face = FaceTop;
    for (int f = NumFaces - 1; f >= 0; f--) begin
      if (rem_q[f]) face = 3'(f);
    end
  end

  always_comb begin
    vd  = vert_lut(face, k_q);
    sel = cur_q.letters[face] & vd.aomask;
    cnt = '0;
    for (int i = 0; i < 8; i++) cnt = cnt + 4'(sel[i]);
    n = (cnt > 4'd3) ? 2'd3 : cnt[1:0];
  end

  always_comb begin
    rem_after       = rem_q;
    rem_after[face] = 1'b0;
  end

  assign out_ready = ~ov_q | m_ready_i;
  assign emit      = busy_q & out_ready;
  assign finish    = emit & (k_q == VertLast) & (rem_after == '0);
  assign load      = (~busy_q | finish) & q_valid_i;
  assign q_pop_o   = load;

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    k_d    = k_q;
    if (emit) begin
      if (k_q == VertLast) begin
        k_d   = VertFirst;
        rem_d = rem_after;
      end else begin
        k_d = k_q + 1'b1;
      end
    end
    if (finish) busy_d = 1'b0;
    if (load) begin
      busy_d = 1'b1;
      rem_d  = q_item_i.open;
      k_d    = VertFirst;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (out_ready) ov_d = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      k_q    <= VertFirst;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      k_q    <= k_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_item_i;
    if (emit) begin
      cx_q    <= 5'(cur_q.x) + 5'(vd.ox);
      cy_q    <= 5'(cur_q.y) + 5'(vd.oy);
      cz_q    <= 5'(cur_q.z) + 5'(vd.oz);
      tu_q    <= 5'(cur_q.u1) + 5'(vd.us);
      tv_q    <= 5'(cur_q.v1) + 5'(vd.vs);
      light_q <= light_lut(face, n);
      face_q  <= face;
      last_q  <= (k_q == VertLast) & (rem_after == '0);
    end
  end

  assign m_valid_o = ov_q;
  assign m_data_o  = {2'b00, light_q, tv_q, tu_q, cz_q, cy_q, cx_q};
  assign m_user_o  = face_q;
  assign m_last_o  = last_q;

  a_busy_has_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0))
    else $error("back busy with no pending face");

  a_vert_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= VertLast)
    else $error("vertex counter out of range");

  a_face_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && k_q == VertLast) |=> (k_q == VertFirst))
    else $error("vertex counter did not wrap after a face");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !finish) |-> !q_pop_o)
    else $error("queue popped while a voxel is still in flight");

endmodule

// File: tb/voxel_face_mesher_ao_tb.sv
// Self-checking stream testbench for the voxel face mesher with ambient occlusion.
module voxel_face_mesher_ao_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vfm_pkg::*;

  typedef struct packed {
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  z;
    logic [7:0]  id;
    logic [26:0] mask;
  } voxel_t;

  typedef struct packed {
    logic [4:0]  cx;
    logic [4:0]  cy;
    logic [4:0]  cz;
    logic [4:0]  u;
    logic [4:0]  v;
    logic [12:0] light;
    logic [2:0]  face;
    logic        is_last;
  } vertex_t;

  // AO letter groups, a in bit 0
  localparam logic [7:0] GrpCde = 8'h1C;
  localparam logic [7:0] GrpBcf = 8'h26;
  localparam logic [7:0] GrpAbg = 8'h43;
  localparam logic [7:0] GrpAdh = 8'h89;

  localparam logic [26:0] AllBlocked = 27'h7FFFFFF;
  localparam logic [26:0] AllFacesShut = 27'h0415410;
  localparam int SettleCycles = 20;

  localparam int OpenBitOf [6] = '{22, 4, 14, 12, 16, 10};

  localparam int AoBitOf [6][8] = '{
    '{23, 25, 21, 19, 18, 24, 26, 20},
    '{ 5,  7,  3,  1,  0,  6,  8,  2},
    '{23, 17,  5, 11,  2,  8, 26, 20},
    '{21, 15,  3,  9,  0,  6, 24, 18},
    '{25, 17,  7, 15,  6,  8, 26, 24},
    '{19, 11,  1,  9,  0,  2, 20, 18}
  };

  localparam logic [12:0] LightQ12 [6][4] = '{
    '{13'd4096, 13'd3482, 13'd2867, 13'd2253},
    '{13'd3072, 13'd2611, 13'd2150, 13'd1690},
    '{13'd3891, 13'd3308, 13'd2724, 13'd2140},
    '{13'd3482, 13'd2959, 13'd2437, 13'd1915},
    '{13'd3686, 13'd3133, 13'd2580, 13'd2028},
    '{13'd3277, 13'd2785, 13'd2294, 13'd1802}
  };

  // Corner and UV offsets per face vertex: {ox, oy, oz, us, vs}
  localparam logic [4:0] VertOfs [6][6] = '{
    '{5'b01010, 5'b01111, 5'b11101, 5'b01010, 5'b11101, 5'b11000},
    '{5'b00000, 5'b10111, 5'b00101, 5'b00000, 5'b10010, 5'b10111},
    '{5'b10010, 5'b11011, 5'b11101, 5'b10010, 5'b11101, 5'b10100},
    '{5'b00000, 5'b01111, 5'b01001, 5'b00000, 5'b00110, 5'b01111},
    '{5'b00100, 5'b11111, 5'b01101, 5'b00100, 5'b10110, 5'b11111},
    '{5'b00010, 5'b01011, 5'b11001, 5'b00010, 5'b11001, 5'b10000}
  };

  localparam logic [7:0] VertGrp [6][6] = '{
    '{GrpCde, GrpBcf, GrpAbg, GrpCde, GrpAbg, GrpAdh},
    '{GrpCde, GrpAbg, GrpAbg, GrpCde, GrpAdh, GrpAbg},
    '{GrpCde, GrpAdh, GrpAbg, GrpCde, GrpAbg, GrpBcf},
    '{GrpCde, GrpAbg, GrpAdh, GrpCde, GrpBcf, GrpAbg},
    '{GrpCde, GrpAbg, GrpAdh, GrpCde, GrpBcf, GrpAbg},
    '{GrpCde, GrpAdh, GrpAbg, GrpCde, GrpAbg, GrpBcf}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [47:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  voxel_t  voxel_queue [$];
  vertex_t expected_verts [$];
  voxel_t  in_flight;
  logic    ao_on = 1'b1;
  bit      idle_on = 1'b1;
  int      src_gap = 0;
  int      sink_gap = 0;
  int      n_queued = 0;
  int      n_meshed = 0;
  int      n_silent = 0;
  int      n_verts = 0;
  int      n_errors = 0;
  int      n_cfg = 0;

  voxel_face_mesher_ao uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Expected vertex stream of one voxel, appended to expected_verts
  function automatic void mesh_voxel(voxel_t vx);
    logic [3:0] px, py, pz;
    logic [7:0] letters;
    logic [4:0] ofs;
    int first;
    int n;
    vertex_t vt;
    first = expected_verts.size();
    px = (32'(vx.x) >= ChunkW) ? 4'(ChunkW - 1) : vx.x;
    py = (32'(vx.y) >= ChunkH) ? 4'(ChunkH - 1) : vx.y;
    pz = (32'(vx.z) >= ChunkD) ? 4'(ChunkD - 1) : vx.z;
    if (vx.id != 8'd0) begin
      for (int f = 0; f < NumFaces; f++) begin
        if (vx.mask[OpenBitOf[f]]) continue;
        letters = '0;
        if (ao_on) begin
          for (int i = 0; i < 8; i++) letters[i] = vx.mask[AoBitOf[f][i]];
        end
        for (int k = 0; k < VertsPerFace; k++) begin
          ofs = VertOfs[f][k];
          n = $countones(letters & VertGrp[f][k]);
          if (n > 3) n = 3;
          vt.cx = 5'(px) + 5'(ofs[4]);
          vt.cy = 5'(py) + 5'(ofs[3]);
          vt.cz = 5'(pz) + 5'(ofs[2]);
          vt.u = 5'(vx.id[3:0]) + 5'(ofs[1]);
          vt.v = 5'(4'd15 - vx.id[7:4]) + 5'(ofs[0]);
          vt.light = LightQ12[f][n];
          vt.face = 3'(f);
          vt.is_last = 1'b0;
          expected_verts.push_back(vt);
        end
      end
    end
    if (expected_verts.size() > first) expected_verts[expected_verts.size() - 1].is_last = 1'b1;
    else n_silent++;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (n_errors < 40) begin
      $display("[%0t] vertex %0d: %s got %0d expected %0d", $time, n_verts, what, got, want);
    end
    n_errors++;
  endtask

  task automatic check_vertex(vertex_t got);
    vertex_t want;
    if (expected_verts.size() == 0) begin
      report_mismatch("unexpected word, tdata low bits", got.cx, 0);
      return;
    end
    want = expected_verts.pop_front();
    if (got.cx !== want.cx) report_mismatch("corner_x", got.cx, want.cx);
    if (got.cy !== want.cy) report_mismatch("corner_y", got.cy, want.cy);
    if (got.cz !== want.cz) report_mismatch("corner_z", got.cz, want.cz);
    if (got.u !== want.u) report_mismatch("tex_u", got.u, want.u);
    if (got.v !== want.v) report_mismatch("tex_v", got.v, want.v);
    if (got.light !== want.light) report_mismatch("light", got.light, want.light);
    if (got.face !== want.face) report_mismatch("face", got.face, want.face);
    if (got.is_last !== want.is_last) report_mismatch("last", got.is_last, want.is_last);
    n_verts++;
  endtask

  // Source side: predict on acceptance, then load the next word or idle
  always @(posedge clk_i) begin
    if (s_tvalid && s_axis_tready_o) begin
      mesh_voxel(in_flight);
      n_meshed++;
    end
    if (!s_tvalid || s_axis_tready_o) begin
      if (src_gap != 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (idle_on && voxel_queue.size() != 0 && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 8);
        s_tvalid <= 1'b0;
      end else if (voxel_queue.size() != 0) begin
        in_flight = voxel_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, in_flight.mask, in_flight.id, in_flight.z, in_flight.y, in_flight.x};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: check accepted words, stall in bursts
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      check_vertex('{m_axis_tdata_o[4:0], m_axis_tdata_o[9:5], m_axis_tdata_o[14:10],
                     m_axis_tdata_o[19:15], m_axis_tdata_o[24:20], m_axis_tdata_o[37:25],
                     m_axis_tuser_o, m_axis_tlast_o});
    end
    if (sink_gap != 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic queue_voxel(voxel_t vx);
    voxel_queue.push_back(vx);
    n_queued++;
  endtask

  function automatic logic [3:0] pick_coord();
    if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 1) ? 4'd15 : 4'd0;
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic voxel_t rand_voxel();
    voxel_t vx;
    int pick;
    pick = $urandom_range(0, 9);
    vx.x = pick_coord();
    vx.y = pick_coord();
    vx.z = pick_coord();
    vx.id = 8'($urandom_range(1, 255));
    vx.mask = 27'($urandom);
    if (pick == 0) begin
      vx.id = 8'd0;
    end else if (pick == 1) begin
      vx.mask = AllBlocked;
    end else if (pick <= 4) begin
      // one visible face, the usual case inside solid terrain
      vx.mask = vx.mask | AllFacesShut;
      vx.mask[OpenBitOf[$urandom_range(0, NumFaces - 1)]] = 1'b0;
    end
    return vx;
  endfunction

  // Wait for every expected vertex, then let the pipeline settle
  task automatic drain();
    while (!(n_meshed == n_queued && expected_verts.size() == 0)) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_ao(logic value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    ao_on = value;
    n_cfg++;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) queue_voxel(rand_voxel());
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_ao(1'b1);

    queue_voxel('{4'd0, 4'd0, 4'd0, 8'd0, 27'd0});
    queue_voxel('{4'd15, 4'd15, 4'd15, 8'd0, AllBlocked});
    queue_voxel('{4'd5, 4'd6, 4'd7, 8'd255, AllBlocked});
    queue_voxel('{4'd0, 4'd0, 4'd0, 8'd1, 27'd0});
    queue_voxel('{4'd15, 4'd15, 4'd15, 8'd255, AllBlocked & ~AllFacesShut});
    // centre bit alone must not hide anything
    queue_voxel('{4'd7, 4'd8, 4'd9, 8'd128, 27'h0002000});
    for (int f = 0; f < NumFaces; f++) begin
      queue_voxel('{4'(f * 3), 4'(15 - f), 4'(f), 8'(f * 51 + 1),
                    AllBlocked & ~(27'd1 << OpenBitOf[f])});
    end
    for (int f = 0; f < NumFaces; f++) begin
      queue_voxel('{pick_coord(), pick_coord(), pick_coord(), 8'(f * 40 + 15),
                    (27'($urandom) & ~AllFacesShut) | (AllFacesShut & ~(27'd1 << OpenBitOf[f]))});
    end
    queue_voxel('{4'd15, 4'd0, 4'd15, 8'hF0, 27'd0});
    queue_voxel('{4'd0, 4'd15, 4'd0, 8'h0F, 27'($urandom)});
    queue_voxel('{4'd8, 4'd8, 4'd8, 8'h10, 27'($urandom)});
    drain();

    write_ao(1'b0);
    queue_voxel('{4'd15, 4'd15, 4'd15, 8'd255, AllBlocked & ~AllFacesShut});
    queue_voxel('{4'd3, 4'd4, 4'd5, 8'd77, 27'($urandom) & ~AllFacesShut});
    run_random(60);

    write_ao(1'b1);
    run_random(150);

    write_ao(1'b0);
    run_random(40);

    write_ao(1'b1);
    idle_on = 1'b0;
    run_random(100);

    for (int i = 0; i < expected_verts.size(); i++) begin
      report_mismatch("missing vertex, face", 0, expected_verts[i].face);
    end
    $display("Meshed %0d voxels (%0d with no visible face), checked %0d vertices",
             n_meshed, n_silent, n_verts);
    $display("AO setting written %0d times, toggling between on and off", n_cfg);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d vertices still expected", expected_verts.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
